/* sv/iprx_pkg.sv */
// Shared types and constants for the IPv4 receive header checker.
package iprx_pkg;

	localparam int DEF_TABLE_ENTRIES = 256;
	localparam int MIN_HEADER        = 20;
	localparam int MAX_HEADER_BYTES  = 60;
	localparam logic [3:0]  IP_VERSION = 4'd4;
	localparam logic [15:0] FRAG_MASK  = 16'h3fff;
	localparam int CFG_IDX_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = 8'd1;

	// header byte offsets
	localparam logic [5:0] OFF_VIHL      = 6'd0;
	localparam logic [5:0] OFF_LEN_HI    = 6'd2;
	localparam logic [5:0] OFF_LEN_LO    = 6'd3;
	localparam logic [5:0] OFF_FRAG_HI   = 6'd6;
	localparam logic [5:0] OFF_FRAG_LO   = 6'd7;
	localparam logic [5:0] OFF_PROTO     = 6'd9;
	localparam logic [5:0] OFF_SRC_FIRST = 6'd12;
	localparam logic [5:0] OFF_SRC_LAST  = 6'd15;
	localparam logic [5:0] OFF_DST_FIRST = 6'd16;
	localparam logic [5:0] OFF_DST_LAST  = 6'd19;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SIZE        = 3'd1,
		ST_FORMAT      = 3'd2,
		ST_CHECKSUM    = 3'd3,
		ST_UNSUPPORTED = 3'd4,
		ST_UNREACHABLE = 3'd5,
		ST_BAD_PARAM   = 3'd6,
		ST_EXISTS      = 3'd7
	} status_t;

	typedef struct packed {
		logic [15:0] count;
		logic [7:0]  vihl;
		logic [15:0] ip_len;
		logic [15:0] frag;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dest;
		logic [15:0] sum;
	} frame_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  handler_tag;
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [31:0] dest_addr;
		logic [5:0]  header_bytes;
		logic [15:0] payload_bytes;
	} result_t;

endpackage

/* sv/iprx_ifs.sv */
// Request, result and configuration channel interfaces.
interface iprx_in_if import iprx_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;
	logic       last;
	logic [7:0] reg_protocol;
	logic [7:0] reg_tag;
	modport source (output valid, cmd, data_byte, last, reg_protocol, reg_tag, input ready);
	modport sink (input valid, cmd, data_byte, last, reg_protocol, reg_tag, output ready);
endinterface

interface iprx_out_if import iprx_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  handler_tag;
	logic [7:0]  protocol;
	logic [31:0] src_addr;
	logic [31:0] dest_addr;
	logic [5:0]  header_bytes;
	logic [15:0] payload_bytes;
	modport source (output valid, status, handler_tag, protocol, src_addr, dest_addr,
		header_bytes, payload_bytes, input ready);
	modport sink (input valid, status, handler_tag, protocol, src_addr, dest_addr,
		header_bytes, payload_bytes, output ready);
endinterface

interface iprx_cfg_if import iprx_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/iprx_capture.sv */
// Per-byte header field capture and running ones-complement sum.
module iprx_capture import iprx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       last,
	output frame_t     nxt
);

	frame_t      cur_q;
	logic [7:0]  hold_q;
	logic [7:0]  hold_n;
	logic [5:0]  ofs;
	logic [5:0]  ihl_bytes;
	logic [16:0] sum_raw;
	logic        in_hdr;

	always_comb begin
		nxt     = cur_q;
		hold_n  = hold_q;
		ofs     = cur_q.count[5:0];
		in_hdr  = cur_q.count < 16'(MAX_HEADER_BYTES);
		sum_raw = 17'(cur_q.sum) + 17'({hold_q, data_byte});
		ihl_bytes = '0;
		if (in_hdr) begin
			case (ofs) inside
				OFF_VIHL:                    nxt.vihl = data_byte;
				OFF_LEN_HI, OFF_LEN_LO:      nxt.ip_len = {cur_q.ip_len[7:0], data_byte};
				OFF_FRAG_HI, OFF_FRAG_LO:    nxt.frag = {cur_q.frag[7:0], data_byte};
				OFF_PROTO:                   nxt.proto = data_byte;
				[OFF_SRC_FIRST:OFF_SRC_LAST]: nxt.src = {cur_q.src[23:0], data_byte};
				[OFF_DST_FIRST:OFF_DST_LAST]: nxt.dest = {cur_q.dest[23:0], data_byte};
				default: ;
			endcase
			ihl_bytes = {nxt.vihl[3:0], 2'b00};
			if (ofs < ihl_bytes) begin
				if (!ofs[0]) begin
					hold_n = data_byte;
				end else begin
					// fold the end-around carry
					nxt.sum = sum_raw[16] ? sum_raw[15:0] + 16'd1 : sum_raw[15:0];
				end
			end
		end
		nxt.count = (cur_q.count == '1) ? cur_q.count : cur_q.count + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			hold_q <= '0;
		end else if (take) begin
			if (last) begin
				cur_q  <= '0;
				hold_q <= '0;
			end else begin
				cur_q  <= nxt;
				hold_q <= hold_n;
			end
		end
	end

endmodule

/* sv/iprx_table.sv */
// Protocol handler table: synchronous memory with valid bits and write forwarding.
module iprx_table import iprx_pkg::*; #(
	parameter int ENTRIES = DEF_TABLE_ENTRIES,
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_tag,
	output logic [7:0]    entry
);

	logic [7:0]         mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [7:0]         rdata_q;
	logic [AW-1:0]      raddr_q;
	logic               fwd_q;
	logic [7:0]         fwd_tag_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_tag;
		end
		if (rd_en) begin
			rdata_q   <= mem[rd_addr];
			fwd_tag_q <= wr_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			raddr_q <= '0;
			fwd_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				raddr_q <= rd_addr;
				// the read misses a write landing on the same edge: take it directly
				fwd_q   <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	assign entry = fwd_q ? fwd_tag_q : (valid_q[raddr_q] ? rdata_q : 8'd0);

endmodule

/* sv/ipv4_receive_header_checker.sv */
// The request stage loads on the accepting edge, the result register once the output can
// advance. Throughput: one request per cycle; a stalled result blocks input only once
// the request stage is full. The handler table is read on the accept edge and written
// as a registration advances, with forwarding between back-to-back requests.
// Reset: asynchronous; clears frame state, configuration and all table valid bits,
// so every protocol starts with no handler and no clearing pass is needed.
module ipv4_receive_header_checker import iprx_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
	input logic        clk,
	input logic        arst_n,
	iprx_in_if.sink    rx,
	iprx_out_if.source res,
	iprx_cfg_if.sink   cfg
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic        rx_acc;
	logic        load_s1;
	logic        adv;
	frame_t      cap_nxt;
	logic [7:0]  entry;
	logic [7:0]  rd_proto;

	logic        s1_valid_q;
	logic        is_reg_s1;
	frame_t      frm_s1;
	logic [7:0]  proto_s1;
	logic [7:0]  rtag_s1;

	logic        out_valid_q;
	result_t     res_q;
	result_t     res_n;

	logic [31:0] local_q;
	logic [31:0] mask_q;

	logic        in_range;
	logic        tbl_wr;
	logic [3:0]  ver;
	logic [5:0]  hs;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q <= '0;
			mask_q  <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_LOCAL_ADDR) begin
				local_q <= cfg.data;
			end
			if (cfg.index == CFG_SUBNET_MASK) begin
				mask_q <= cfg.data;
			end
		end
	end

	assign adv      = !out_valid_q || res.ready;
	assign rx.ready = !s1_valid_q || adv;
	assign rx_acc   = rx.valid && rx.ready;
	assign load_s1  = rx_acc && (rx.cmd || rx.last);
	assign rd_proto = rx.cmd ? rx.reg_protocol : cap_nxt.proto;

	iprx_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (rx_acc && !rx.cmd),
		.data_byte (rx.data_byte),
		.last      (rx.last),
		.nxt       (cap_nxt)
	);

	iprx_table #(
		.ENTRIES (TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (load_s1),
		.rd_addr (rd_proto[AW-1:0]),
		.wr_en   (tbl_wr),
		.wr_addr (proto_s1[AW-1:0]),
		.wr_tag  (rtag_s1),
		.entry   (entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (load_s1) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			is_reg_s1 <= rx.cmd;
			frm_s1    <= cap_nxt;
			proto_s1  <= rd_proto;
			rtag_s1   <= rx.reg_tag;
		end
	end

	// verdict
	always_comb begin
		in_range = 9'(proto_s1) < 9'(TABLE_ENTRIES);
		ver      = frm_s1.vihl[7:4];
		hs       = {frm_s1.vihl[3:0], 2'b00};
		tbl_wr   = 1'b0;
		res_n    = '0;
		if (is_reg_s1) begin
			if (rtag_s1 == 8'd0 || !in_range) begin
				res_n.status = ST_BAD_PARAM;
			end else if (entry != 8'd0) begin
				res_n.status = ST_EXISTS;
			end else begin
				res_n.status = ST_OK;
				tbl_wr       = s1_valid_q && adv;
			end
		end else if (frm_s1.count < 16'(MIN_HEADER)) begin
			res_n.status = ST_SIZE;
		end else if (ver != IP_VERSION || hs < 6'(MIN_HEADER) || hs > 6'(MAX_HEADER_BYTES)
				|| 16'(hs) > frm_s1.count) begin
			res_n.status = ST_FORMAT;
		end else if (frm_s1.ip_len < 16'(hs) || frm_s1.ip_len > frm_s1.count) begin
			res_n.status = ST_SIZE;
		end else if (frm_s1.sum != 16'hffff) begin
			res_n.status = ST_CHECKSUM;
		end else if ((frm_s1.frag & FRAG_MASK) != 16'd0) begin
			res_n.status = ST_UNSUPPORTED;
		end else if ((frm_s1.dest & mask_q) != (local_q & mask_q)) begin
			res_n.status = ST_UNREACHABLE;
		end else if (!in_range || entry == 8'd0) begin
			res_n.status = ST_UNSUPPORTED;
		end else begin
			res_n.status        = ST_OK;
			res_n.handler_tag   = entry;
			res_n.protocol      = frm_s1.proto;
			res_n.src_addr      = frm_s1.src;
			res_n.dest_addr     = frm_s1.dest;
			res_n.header_bytes  = hs;
			res_n.payload_bytes = frm_s1.ip_len - 16'(hs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && adv) begin
			res_q <= res_n;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = res_q.status;
	assign res.handler_tag   = res_q.handler_tag;
	assign res.protocol      = res_q.protocol;
	assign res.src_addr      = res_q.src_addr;
	assign res.dest_addr     = res_q.dest_addr;
	assign res.header_bytes  = res_q.header_bytes;
	assign res.payload_bytes = res_q.payload_bytes;

`ifndef SYNTHESIS
	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status != ST_OK) |->
		(res.handler_tag == 8'd0 && res.src_addr == 32'd0 && res.dest_addr == 32'd0
		&& res.header_bytes == 6'd0 && res.payload_bytes == 16'd0))
		else $error("failed verdict carries nonzero fields");

	a_ok_header_len: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == ST_OK && res.handler_tag != 8'd0) |->
		(res.header_bytes >= 6'(MIN_HEADER) && res.header_bytes <= 6'(MAX_HEADER_BYTES)))
		else $error("accepted packet with header length out of range");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !res.ready) |-> !rx.ready)
		else $error("request taken while the pipeline is stalled");

	a_table_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr |-> (entry == 8'd0 && rtag_s1 != 8'd0))
		else $error("handler slot overwritten or zero tag stored");
`endif

endmodule

/* dv/tb_ipv4_receive_header_checker.sv */
// Self-checking testbench for the IPv4 receive header checker: byte streams vs. a local verdict model.
`timescale 1ns / 100ps

module tb_ipv4_receive_header_checker;
	import iprx_pkg::*;

	localparam int TBL_ENTRIES = DEF_TABLE_ENTRIES;
	localparam logic CMD_FRAME    = 1'b0;
	localparam logic CMD_REGISTER = 1'b1;
	localparam logic [15:0] FLAG_RSV = 16'h8000;
	localparam logic [15:0] FLAG_DF  = 16'h4000;
	localparam logic [15:0] FLAG_MF  = 16'h2000;

	logic clk = 1'b0;
	logic arst_n;

	iprx_in_if  rx_ch ();
	iprx_out_if res_ch ();
	iprx_cfg_if cfg_ch ();

	ipv4_receive_header_checker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	// verdict model state
	logic [7:0]  tbl_tags [TBL_ENTRIES];
	logic [15:0] rx_count;
	logic [7:0]  vihl_r;
	logic [15:0] tot_len_r;
	logic [15:0] frag_r;
	logic [7:0]  proto_r;
	logic [31:0] src_r;
	logic [31:0] dst_r;
	logic [16:0] csum_r;
	logic [7:0]  hi_hold_r;
	logic [31:0] local_addr_r;
	logic [31:0] mask_r;

	result_t pending_verdicts [$];
	logic [7:0] hdr_q [$];

	int err_count;
	int sent_items;
	int send_idle_pct;
	int recv_idle_pct;
	int mix_pct;

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(negedge clk) begin
		res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void clear_frame();
		rx_count  = '0;
		vihl_r    = '0;
		tot_len_r = '0;
		frag_r    = '0;
		proto_r   = '0;
		src_r     = '0;
		dst_r     = '0;
		csum_r    = '0;
		hi_hold_r = '0;
	endfunction

	function automatic void reset_model();
		local_addr_r = '0;
		mask_r       = '0;
		foreach (tbl_tags[i]) tbl_tags[i] = '0;
		clear_frame();
	endfunction

	function automatic void capture_byte(logic [15:0] idx, logic [7:0] b);
		int unsigned hl;
		if (idx >= MAX_HEADER_BYTES)
			return;
		if (idx == OFF_VIHL)
			vihl_r = b;
		else if (idx == OFF_LEN_HI || idx == OFF_LEN_LO)
			tot_len_r = {tot_len_r[7:0], b};
		else if (idx == OFF_FRAG_HI || idx == OFF_FRAG_LO)
			frag_r = {frag_r[7:0], b};
		else if (idx == OFF_PROTO)
			proto_r = b;
		else if (idx >= OFF_SRC_FIRST && idx <= OFF_SRC_LAST)
			src_r = {src_r[23:0], b};
		else if (idx >= OFF_DST_FIRST && idx <= OFF_DST_LAST)
			dst_r = {dst_r[23:0], b};
		hl = vihl_r[3:0] * 4;
		if (idx < hl) begin
			if (!idx[0]) begin
				hi_hold_r = b;
			end else begin
				csum_r = csum_r + {1'b0, hi_hold_r, b};
				// end-around carry
				if (csum_r[16])
					csum_r = {1'b0, csum_r[15:0]} + 17'd1;
			end
		end
	endfunction

	function automatic result_t judge_frame(logic [15:0] n);
		result_t r;
		int unsigned hs;
		logic [7:0] tag;
		r = '0;
		hs = vihl_r[3:0] * 4;
		if (n < MIN_HEADER)
			r.status = ST_SIZE;
		else if (vihl_r[7:4] != IP_VERSION || hs < MIN_HEADER || hs > MAX_HEADER_BYTES || hs > n)
			r.status = ST_FORMAT;
		else if (tot_len_r < hs || tot_len_r > n)
			r.status = ST_SIZE;
		else if (csum_r != 17'h0ffff)
			r.status = ST_CHECKSUM;
		else if ((frag_r & FRAG_MASK) != 0)
			r.status = ST_UNSUPPORTED;
		else if ((dst_r & mask_r) != (local_addr_r & mask_r))
			r.status = ST_UNREACHABLE;
		else begin
			tag = (proto_r < TBL_ENTRIES) ? tbl_tags[proto_r] : 8'd0;
			if (tag == 0) begin
				r.status = ST_UNSUPPORTED;
			end else begin
				r.status        = ST_OK;
				r.handler_tag   = tag;
				r.protocol      = proto_r;
				r.src_addr      = src_r;
				r.dest_addr     = dst_r;
				r.header_bytes  = 6'(hs);
				r.payload_bytes = tot_len_r - 16'(hs);
			end
		end
		return r;
	endfunction

	function automatic void predict_request(logic c, logic [7:0] b, logic l, logic [7:0] rp,
			logic [7:0] rt);
		result_t r;
		r = '0;
		if (c == CMD_REGISTER) begin
			if (rt == 0 || rp >= TBL_ENTRIES)
				r.status = ST_BAD_PARAM;
			else if (tbl_tags[rp] != 0)
				r.status = ST_EXISTS;
			else begin
				tbl_tags[rp] = rt;
				r.status = ST_OK;
			end
			pending_verdicts.push_back(r);
		end else begin
			capture_byte(rx_count, b);
			if (rx_count != 16'hffff)
				rx_count = rx_count + 16'd1;
			if (l) begin
				pending_verdicts.push_back(judge_frame(rx_count));
				clear_frame();
			end
		end
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result, status %0d", res_ch.status);
				err_count++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("status", want.status, res_ch.status);
				check_field("handler_tag", want.handler_tag, res_ch.handler_tag);
				check_field("protocol", want.protocol, res_ch.protocol);
				check_field("src_addr", want.src_addr, res_ch.src_addr);
				check_field("dest_addr", want.dest_addr, res_ch.dest_addr);
				check_field("header_bytes", want.header_bytes, res_ch.header_bytes);
				check_field("payload_bytes", want.payload_bytes, res_ch.payload_bytes);
			end
		end
	end

	task automatic send_request(logic c, logic [7:0] b, logic l, logic [7:0] rp, logic [7:0] rt);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_ch.valid = 1'b0;
			@(negedge clk);
		end
		rx_ch.valid        = 1'b1;
		rx_ch.cmd          = c;
		rx_ch.data_byte    = b;
		rx_ch.last         = l;
		rx_ch.reg_protocol = rp;
		rx_ch.reg_tag      = rt;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		predict_request(c, b, l, rp, rt);
		sent_items++;
	endtask

	task automatic send_byte(logic [7:0] b, logic l);
		send_request(CMD_FRAME, b, l, 8'($urandom), 8'($urandom));
	endtask

	task automatic send_register(logic [7:0] rp, logic [7:0] rt);
		send_request(CMD_REGISTER, 8'($urandom), 1'($urandom), rp, rt);
	endtask

	// send hdr_len bytes of hdr_q, then extra payload bytes; last on the final one
	task automatic send_frame(int hdr_len, int extra);
		int n;
		n = hdr_len + extra;
		for (int i = 0; i < n; i++) begin
			if (mix_pct != 0 && $urandom_range(99) < mix_pct)
				send_register(8'($urandom), 8'($urandom));
			send_byte((i < hdr_len) ? hdr_q[i] : 8'($urandom), i == n - 1);
		end
	endtask

	// hold off until every verdict is back and the pipeline has emptied
	task automatic settle();
		@(negedge clk);
		rx_ch.valid = 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		settle();
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == CFG_LOCAL_ADDR)
			local_addr_r = val;
		else if (idx == CFG_SUBNET_MASK)
			mask_r = val;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// fill hdr_q with a header carrying a correct checksum over the IHL span
	function automatic void build_header(logic [3:0] ver, logic [3:0] ihl, logic [15:0] tot,
			logic [15:0] frag, logic [7:0] proto, logic [31:0] src, logic [31:0] dst);
		int hl;
		int sz;
		logic [16:0] acc;
		logic [15:0] cs;
		hl = ihl * 4;
		sz = (hl > MIN_HEADER) ? hl : MIN_HEADER;
		hdr_q.delete();
		hdr_q.push_back({ver, ihl});
		hdr_q.push_back(8'($urandom));
		hdr_q.push_back(tot[15:8]);
		hdr_q.push_back(tot[7:0]);
		hdr_q.push_back(8'($urandom));
		hdr_q.push_back(8'($urandom));
		hdr_q.push_back(frag[15:8]);
		hdr_q.push_back(frag[7:0]);
		hdr_q.push_back(8'($urandom));
		hdr_q.push_back(proto);
		hdr_q.push_back(8'd0);
		hdr_q.push_back(8'd0);
		for (int i = 3; i >= 0; i--) hdr_q.push_back(src[i*8 +: 8]);
		for (int i = 3; i >= 0; i--) hdr_q.push_back(dst[i*8 +: 8]);
		while (hdr_q.size() < sz)
			hdr_q.push_back(8'($urandom));
		acc = '0;
		for (int i = 0; i + 1 < hl; i += 2) begin
			acc = acc + {1'b0, hdr_q[i], hdr_q[i+1]};
			if (acc[16])
				acc = {1'b0, acc[15:0]} + 17'd1;
		end
		cs = ~acc[15:0];
		hdr_q[10] = cs[15:8];
		hdr_q[11] = cs[7:0];
	endfunction

	function automatic logic [31:0] good_dest();
		return (local_addr_r & mask_r) | (32'($urandom) & ~mask_r);
	endfunction

	// prefer a protocol that already has a handler
	function automatic logic [7:0] pick_proto();
		logic [7:0] p;
		p = 8'($urandom);
		for (int k = 0; k < 64 && tbl_tags[p] == 0; k++)
			p = 8'($urandom);
		return p;
	endfunction

	task automatic test_handler_registration();
		send_register(8'd6, 8'ha5);
		send_register(8'd17, 8'h5a);
		send_register(8'd0, 8'h01);
		send_register(8'd255, 8'hff);
		send_register(8'd9, 8'h00);
		send_register(8'd6, 8'h03);
		send_register(8'd255, 8'h00);
	endtask

	task automatic test_accepted_frames();
		write_config(CFG_LOCAL_ADDR, 32'hc0a8_0164);
		write_config(CFG_SUBNET_MASK, 32'hffff_ff00);
		build_header(IP_VERSION, 4'd5, 16'd20, 16'h0000, 8'd6, 32'($urandom), good_dest());
		send_frame(20, 0);
		build_header(IP_VERSION, 4'd15, 16'd68, FLAG_DF, 8'd17, 32'($urandom), good_dest());
		send_frame(60, 11);
		build_header(IP_VERSION, 4'd6, 16'd40, FLAG_RSV, 8'd255, 32'hffff_ffff, good_dest());
		send_frame(24, 16);
		build_header(IP_VERSION, 4'd5, 16'd28, 16'h0000, 8'd0, 32'h0000_0000, good_dest());
		send_frame(20, 8);
	endtask

	task automatic test_rejected_frames();
		build_header(IP_VERSION, 4'd5, 16'd20, 16'h0000, 8'd6, 32'($urandom), good_dest());
		send_frame(1, 0);
		send_frame(19, 0);
		build_header(4'd6, 4'd5, 16'd20, 16'h0000, 8'd6, 32'($urandom), good_dest());
		send_frame(20, 0);
		build_header(IP_VERSION, 4'd4, 16'd20, 16'h0000, 8'd6, 32'($urandom), good_dest());
		send_frame(20, 0);
		build_header(IP_VERSION, 4'd15, 16'd60, 16'h0000, 8'd6, 32'($urandom), good_dest());
		send_frame(40, 0);
		build_header(IP_VERSION, 4'd5, 16'd19, 16'h0000, 8'd6, 32'($urandom), good_dest());
		send_frame(20, 0);
		build_header(IP_VERSION, 4'd5, 16'd100, 16'h0000, 8'd6, 32'($urandom), good_dest());
		send_frame(20, 10);
		build_header(IP_VERSION, 4'd5, 16'd20, 16'h0000, 8'd6, 32'($urandom), good_dest());
		hdr_q[1] = hdr_q[1] ^ 8'h01;
		send_frame(20, 0);
		build_header(IP_VERSION, 4'd5, 16'd20, FLAG_MF, 8'd6, 32'($urandom), good_dest());
		send_frame(20, 0);
		build_header(IP_VERSION, 4'd5, 16'd20, 16'h1fff, 8'd6, 32'($urandom), good_dest());
		send_frame(20, 0);
		build_header(IP_VERSION, 4'd5, 16'd20, 16'h0000, 8'd6, 32'($urandom),
			local_addr_r ^ 32'h0000_0100);
		send_frame(20, 0);
		build_header(IP_VERSION, 4'd5, 16'd20, 16'h0000, 8'd200, 32'($urandom), good_dest());
		send_frame(20, 0);
	endtask

	task automatic test_register_mid_frame();
		build_header(IP_VERSION, 4'd5, 16'd24, 16'h0000, 8'd17, 32'($urandom), good_dest());
		for (int i = 0; i < 24; i++) begin
			if (i == 9)
				send_register(8'd42, 8'h99);
			if (i == 15)
				send_register(8'd17, 8'h77);
			send_byte((i < 20) ? hdr_q[i] : 8'($urandom), i == 23);
		end
	endtask

	task automatic test_subnet_match();
		write_config(CFG_LOCAL_ADDR, 32'hffff_ffff);
		write_config(CFG_SUBNET_MASK, 32'h0000_0000);
		build_header(IP_VERSION, 4'd5, 16'd20, 16'h0000, 8'd6, 32'($urandom), 32'($urandom));
		send_frame(20, 0);
		write_config(CFG_LOCAL_ADDR, 32'h0000_0000);
		write_config(CFG_SUBNET_MASK, 32'hffff_ffff);
		build_header(IP_VERSION, 4'd5, 16'd20, 16'h0000, 8'd6, 32'($urandom), 32'h0000_0000);
		send_frame(20, 0);
		build_header(IP_VERSION, 4'd5, 16'd20, 16'h0000, 8'd6, 32'($urandom), 32'h0000_0001);
		send_frame(20, 0);
	endtask

	task automatic test_random_traffic(int send_pct, int recv_pct, logic [31:0] addr,
			logic [31:0] mask, int n_items);
		int stop_at, kind, flaw, ihl, pay, hdr_len, extra, k;
		logic [3:0]  ver;
		logic [15:0] tot;
		logic [15:0] frag;
		logic [7:0]  proto;
		logic [31:0] dst;
		write_config(CFG_LOCAL_ADDR, addr);
		write_config(CFG_SUBNET_MASK, mask);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		mix_pct = 2;
		stop_at = sent_items + n_items;
		while (sent_items < stop_at) begin
			kind = $urandom_range(99);
			if (kind < 20) begin
				send_register(($urandom_range(3) == 0) ? pick_proto() : 8'($urandom),
					($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
			end else begin
				ver   = IP_VERSION;
				ihl   = ($urandom_range(2) == 0) ? $urandom_range(5, 15) : 5;
				pay   = $urandom_range(12);
				tot   = 16'(ihl * 4 + pay);
				frag  = {2'($urandom), 14'd0};
				proto = pick_proto();
				dst   = good_dest();
				flaw  = (kind < 75) ? -1 : $urandom_range(8);
				case (flaw)
					0: ver   = 4'($urandom);
					1: ihl   = $urandom_range(4);
					2: tot   = 16'($urandom);
					3: frag  = 16'($urandom);
					4: dst   = 32'($urandom);
					5: proto = 8'($urandom);
					default: ;
				endcase
				build_header(ver, 4'(ihl), tot, frag, proto, 32'($urandom), dst);
				hdr_len = hdr_q.size();
				extra = pay + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
				if (flaw == 6) begin
					k = $urandom_range(hdr_len - 1);
					hdr_q[k] = hdr_q[k] ^ 8'(1 << $urandom_range(7));
				end else if (flaw == 7) begin
					hdr_len = $urandom_range(1, hdr_len - 1);
					extra = 0;
				end else if (flaw == 8) begin
					hdr_q.delete();
					hdr_len = $urandom_range(1, 64);
					repeat (hdr_len) hdr_q.push_back(8'($urandom));
					extra = 0;
				end
				send_frame(hdr_len, extra);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		err_count = 0;
		sent_items = 0;
		send_idle_pct = 11;
		recv_idle_pct = 83;
		mix_pct = 0;
		rx_ch.valid = 1'b0;
		rx_ch.cmd = CMD_FRAME;
		rx_ch.data_byte = '0;
		rx_ch.last = 1'b0;
		rx_ch.reg_protocol = '0;
		rx_ch.reg_tag = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_LOCAL_ADDR;
		cfg_ch.data = '0;
		reset_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_handler_registration();
		test_accepted_frames();
		test_rejected_frames();
		test_register_mid_frame();
		test_subnet_match();
		test_random_traffic(11, 83, 32'($urandom), 32'hffff_ff00, 480);
		test_random_traffic(83, 11, 32'hffff_ffff, 32'hffff_ffff, 480);
		test_random_traffic(0, 0, 32'h0a00_0001, 32'hff00_0000, 480);

		settle();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
